// ===== rtl/core/shd_pkg.sv =====
`default_nettype none

package shd_pkg;

   localparam int unsigned NUM_CONSOLES = 10;

   localparam logic [7:0] SC_ESC_PREFIX = 8'hE0;
   localparam logic [7:0] SC_RELEASE    = 8'h80;
   localparam logic [7:0] SC_KEY_MASK   = 8'h7F;
   localparam logic [7:0] SC_LSHIFT     = 8'h2A;
   localparam logic [7:0] SC_LALT       = 8'h38;
   localparam logic [7:0] SC_LCTRL      = 8'h1D;
   localparam logic [7:0] SC_C          = 8'h2E;
   localparam logic [7:0] SC_S          = 8'h1F;
   localparam logic [7:0] SC_Q          = 8'h10;
   localparam logic [7:0] SC_DEL        = 8'h53;
   localparam logic [7:0] SC_BREAK      = 8'h46;
   localparam logic [7:0] SC_F1         = 8'h3B;

   localparam logic [1:0] ACT_PASS    = 2'd0;
   localparam logic [1:0] ACT_CHAR    = 2'd1;
   localparam logic [1:0] ACT_CONSOLE = 2'd2;
   localparam logic [1:0] ACT_RESET   = 2'd3;

   localparam logic [4:0] CHR_ETX = 5'd3;
   localparam logic [4:0] CHR_DC1 = 5'd17;
   localparam logic [4:0] CHR_DC3 = 5'd19;

   typedef struct packed {
      logic escape_pending;
      logic alt_down;
      logic left_ctrl_down;
      logic right_ctrl_down;
      logic shift_down;
   } key_state_type;

   typedef struct packed {
      logic [1:0] action;
      logic [4:0] control_char;
      logic [3:0] console_index;
   } decision_type;

endpackage

`default_nettype wire

// ===== rtl/core/shd_decode.sv =====
`default_nettype none

module shd_decode (
   input  wire logic [7:0]            code,
   input  wire shd_pkg::key_state_type state_cur,
   output shd_pkg::key_state_type      state_nxt,
   output shd_pkg::decision_type       decision
);
   import shd_pkg::*;

   logic [7:0] key;
   logic [7:0] f_off;
   logic       release_code;
   logic       any_ctrl;
   logic       console_hit;

   assign key          = code & SC_KEY_MASK;
   assign release_code = (code & SC_RELEASE) != 8'd0;
   assign any_ctrl     = state_cur.left_ctrl_down | state_cur.right_ctrl_down;
   assign f_off        = code - SC_F1;
   assign console_hit  = state_cur.left_ctrl_down && (code >= SC_F1)
                         && (f_off < 8'(NUM_CONSOLES));

   always_comb begin
      state_nxt              = state_cur;
      decision.action        = ACT_PASS;
      decision.control_char  = 5'd0;
      decision.console_index = 4'd0;
      if (!state_cur.escape_pending) begin
         if (release_code) begin
            if (code == SC_ESC_PREFIX) begin
               state_nxt.escape_pending = 1'b1;
            end else if (key == SC_LALT) begin
               state_nxt.alt_down = 1'b0;
            end else if (key == SC_LCTRL) begin
               state_nxt.left_ctrl_down = 1'b0;
            end else if (key == SC_LSHIFT) begin
               state_nxt.shift_down = 1'b0;
            end
         end else if (console_hit) begin
            decision.action        = ACT_CONSOLE;
            decision.console_index = f_off[3:0];
         end else if (code == SC_LALT) begin
            state_nxt.alt_down = 1'b1;
         end else if (code == SC_LCTRL) begin
            state_nxt.left_ctrl_down = 1'b1;
         end else if (code == SC_LSHIFT) begin
            state_nxt.shift_down = 1'b1;
         end else if (code == SC_C && any_ctrl) begin
            decision.action       = ACT_CHAR;
            decision.control_char = CHR_ETX;
         end else if (code == SC_S && any_ctrl) begin
            decision.action       = ACT_CHAR;
            decision.control_char = CHR_DC3;
         end else if (code == SC_Q && any_ctrl) begin
            decision.action       = ACT_CHAR;
            decision.control_char = CHR_DC1;
         end
      end else begin
         // any byte after the prefix ends the escape sequence
         state_nxt.escape_pending = 1'b0;
         if (release_code) begin
            if (key == SC_LCTRL) begin
               state_nxt.right_ctrl_down = 1'b0;
            end
         end else if (code == SC_LCTRL) begin
            state_nxt.right_ctrl_down = 1'b1;
         end else if (code == SC_DEL && state_cur.left_ctrl_down && state_cur.alt_down) begin
            decision.action = ACT_RESET;
         end else if (code == SC_BREAK) begin
            decision.action       = ACT_CHAR;
            decision.control_char = CHR_ETX;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/scancode_hotkey_decoder_top.sv =====
`default_nettype none
// Two register stages (input register, then result register); a req transfer loads the
// input register, and its decode moves to the result register, raising rsp_valid, when the result side is free.
// Throughput: one scancode per cycle; both stages advance together whenever the
// result register is empty or being taken.
// Reset (synchronous, active high) clears the prefix and modifier flags and both
// stage valids; the first code after reset sees no modifier held.

module scancode_hotkey_decoder_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_scancode,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_action,
   output logic [4:0]      rsp_control_char,
   output logic [3:0]      rsp_console_index,
   output logic            rsp_alt_held,
   output logic            rsp_left_ctrl_held,
   output logic            rsp_right_ctrl_held,
   output logic            rsp_shift_held
);
   import shd_pkg::*;

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_code_ff, in_code_in;
   key_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   decision_type  out_dec_ff, out_dec_in;
   key_state_type out_flags_ff, out_flags_in;

   key_state_type dec_state;
   decision_type  dec_result;
   logic          out_load;
   logic          in_load;

   shd_decode u_decode (
      .code      (in_code_ff),
      .state_cur (state_ff),
      .state_nxt (dec_state),
      .decision  (dec_result)
   );

   // result register frees up when empty or when its transfer completes
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign in_load   = !in_valid_ff || out_load;
   assign req_stall = !in_load;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_code_in   = in_code_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_dec_in   = out_dec_ff;
      out_flags_in = out_flags_ff;
      if (out_load) begin
         out_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            out_dec_in   = dec_result;
            out_flags_in = dec_state;
            state_in     = dec_state;
         end
      end
      if (in_load) begin
         in_valid_in = req_valid;
         in_code_in  = req_scancode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_code_ff   <= in_code_in;
      out_dec_ff   <= out_dec_in;
      out_flags_ff <= out_flags_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_action          = out_dec_ff.action;
   assign rsp_control_char    = out_dec_ff.control_char;
   assign rsp_console_index   = out_dec_ff.console_index;
   assign rsp_alt_held        = out_flags_ff.alt_down;
   assign rsp_left_ctrl_held  = out_flags_ff.left_ctrl_down;
   assign rsp_right_ctrl_held = out_flags_ff.right_ctrl_down;
   assign rsp_shift_held      = out_flags_ff.shift_down;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff))
      else $error("input stalled with a free stage");

   a_console_needs_lctrl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_CONSOLE) |-> rsp_left_ctrl_held)
      else $error("console switch without left ctrl");

   a_reset_combo_mods: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_RESET) |-> (rsp_left_ctrl_held && rsp_alt_held))
      else $error("reset combo without ctrl and alt");

   a_char_only_on_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action != ACT_CHAR) |-> (rsp_control_char == 5'd0))
      else $error("control char set outside a char decision");

endmodule

`default_nettype wire

// ===== tb/tb_scancode_hotkey_decoder_top.sv =====
`default_nettype none

module tb_scancode_hotkey_decoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   import shd_pkg::*;

   typedef struct packed {
      logic [1:0] action;
      logic [4:0] control_char;
      logic [3:0] console_index;
      logic       alt_held;
      logic       left_ctrl_held;
      logic       right_ctrl_held;
      logic       shift_held;
   } hotkey_outcome_type;

   // One offered scancode; answer is used only when typed is set.
   typedef struct packed {
      logic [7:0]         code;
      logic               typed;
      hotkey_outcome_type answer;
   } stim_row_type;

   localparam hotkey_outcome_type NO_ANSWER = '0;
   localparam int DIRECTED_ROWS = 26;
   localparam int SEGMENTS = 8;
   localparam int SEGMENT_ITEMS = 200;
   localparam int LONG_HOLD = 200;
   localparam int SETTLE_CYCLES = 10;
   localparam int CYCLE_LIMIT = 400000;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_scancode = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_action;
   logic [4:0] rsp_control_char;
   logic [3:0] rsp_console_index;
   logic       rsp_alt_held;
   logic       rsp_left_ctrl_held;
   logic       rsp_right_ctrl_held;
   logic       rsp_shift_held;

   key_state_type      keys;
   stim_row_type       offered_rows[$];
   hotkey_outcome_type expected_decisions[$];
   stim_row_type       directed_table [DIRECTED_ROWS];

   int unsigned send_gap_max = 15;
   int unsigned recv_wait_max = 15;
   bit          hold_request = 1'b0;
   int          sent_count = 0;
   int          results_seen = 0;
   int          failures = 0;
   int          cycle_count;
   int          action_tally [4];

   scancode_hotkey_decoder_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_scancode        (req_scancode),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_control_char    (rsp_control_char),
      .rsp_console_index   (rsp_console_index),
      .rsp_alt_held        (rsp_alt_held),
      .rsp_left_ctrl_held  (rsp_left_ctrl_held),
      .rsp_right_ctrl_held (rsp_right_ctrl_held),
      .rsp_shift_held      (rsp_shift_held)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("scancode_hotkey_decoder_top regression: fail");
      $finish;
   end

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%0t: %s", $time, msg);
   endtask

   // Decode one scancode against the tracked prefix and modifier flags.
   function automatic hotkey_outcome_type decode_scancode(input logic [7:0] code);
      hotkey_outcome_type r;
      logic [7:0]         key;
      logic [7:0]         offset;
      logic               released;
      logic               any_ctrl;
      r = '0;
      key = code & SC_KEY_MASK;
      offset = code - SC_F1;
      released = (code & SC_RELEASE) != 8'h00;
      any_ctrl = keys.left_ctrl_down | keys.right_ctrl_down;
      if (!keys.escape_pending) begin
         if (released) begin
            if (code == SC_ESC_PREFIX) keys.escape_pending = 1'b1;
            else if (key == SC_LALT) keys.alt_down = 1'b0;
            else if (key == SC_LCTRL) keys.left_ctrl_down = 1'b0;
            else if (key == SC_LSHIFT) keys.shift_down = 1'b0;
         end else if (keys.left_ctrl_down && code >= SC_F1 &&
                      32'(code) < 32'(SC_F1) + NUM_CONSOLES) begin
            r.action = ACT_CONSOLE;
            r.console_index = offset[3:0];
         end else if (code == SC_LALT) begin
            keys.alt_down = 1'b1;
         end else if (code == SC_LCTRL) begin
            keys.left_ctrl_down = 1'b1;
         end else if (code == SC_LSHIFT) begin
            keys.shift_down = 1'b1;
         end else if (code == SC_C && any_ctrl) begin
            r.action = ACT_CHAR;
            r.control_char = CHR_ETX;
         end else if (code == SC_S && any_ctrl) begin
            r.action = ACT_CHAR;
            r.control_char = CHR_DC3;
         end else if (code == SC_Q && any_ctrl) begin
            r.action = ACT_CHAR;
            r.control_char = CHR_DC1;
         end
      end else begin
         // Any code after the prefix consumes it.
         keys.escape_pending = 1'b0;
         if (released) begin
            if (key == SC_LCTRL) keys.right_ctrl_down = 1'b0;
         end else if (code == SC_LCTRL) begin
            keys.right_ctrl_down = 1'b1;
         end else if (code == SC_DEL && keys.left_ctrl_down && keys.alt_down) begin
            r.action = ACT_RESET;
         end else if (code == SC_BREAK) begin
            r.action = ACT_CHAR;
            r.control_char = CHR_ETX;
         end
      end
      r.alt_held = keys.alt_down;
      r.left_ctrl_held = keys.left_ctrl_down;
      r.right_ctrl_held = keys.right_ctrl_down;
      r.shift_held = keys.shift_down;
      return r;
   endfunction

   always @(posedge clock) begin : scoreboard
      stim_row_type       row;
      hotkey_outcome_type predicted;
      hotkey_outcome_type seen;
      hotkey_outcome_type want;
      if (reset) begin
         keys = '0;
      end else begin
         if (req_valid && !req_stall) begin
            row = offered_rows.pop_front();
            predicted = decode_scancode(req_scancode);
            expected_decisions.push_back(row.typed ? row.answer : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_action, rsp_control_char, rsp_console_index, rsp_alt_held,
                    rsp_left_ctrl_held, rsp_right_ctrl_held, rsp_shift_held};
            results_seen++;
            if (expected_decisions.size() == 0) begin
               note_failure("result transfer with no decision pending");
            end else begin
               want = expected_decisions.pop_front();
               action_tally[want.action]++;
               if (seen.action !== want.action ||
                   seen.control_char !== want.control_char ||
                   seen.console_index !== want.console_index ||
                   seen.alt_held !== want.alt_held ||
                   seen.left_ctrl_held !== want.left_ctrl_held ||
                   seen.right_ctrl_held !== want.right_ctrl_held ||
                   seen.shift_held !== want.shift_held)
                  note_failure($sformatf(
                     "decision %0d: exp %0d/%0d/%0d/%b%b%b%b got %0d/%0d/%0d/%b%b%b%b",
                     results_seen, want.action, want.control_char, want.console_index,
                     want.alt_held, want.left_ctrl_held, want.right_ctrl_held,
                     want.shift_held, seen.action, seen.control_char, seen.console_index,
                     seen.alt_held, seen.left_ctrl_held, seen.right_ctrl_held,
                     seen.shift_held));
            end
         end
      end
   end

   // Result side: stall a random number of cycles per transfer, or one long hold.
   initial begin : receiver
      int unsigned wait_cycles;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            wait_cycles = LONG_HOLD;
         end else begin
            wait_cycles = $urandom_range(0, recv_wait_max);
         end
         if (wait_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_code(input logic [7:0] code, input logic typed,
                            input hotkey_outcome_type answer);
      int unsigned  gap;
      stim_row_type row;
      gap = $urandom_range(0, send_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      row = {code, typed, answer};
      offered_rows.push_back(row);
      req_valid <= 1'b1;
      req_scancode <= code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // Hold the sender until every decision already offered has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_seen < sent_count);
   endtask

   initial begin : stimulus
      logic [7:0] code;
      int unsigned choice;
      directed_table = '{
         {8'h00,                    1'b1, ACT_PASS,    5'd0,    4'd0, 4'b0000},
         {8'hFF,                    1'b1, ACT_PASS,    5'd0,    4'd0, 4'b0000},
         {SC_LCTRL,                 1'b1, ACT_PASS,    5'd0,    4'd0, 4'b0100},
         {SC_F1,                    1'b1, ACT_CONSOLE, 5'd0,    4'd0, 4'b0100},
         {SC_F1 + 8'd9,             1'b1, ACT_CONSOLE, 5'd0,    4'd9, 4'b0100},
         {SC_F1 + 8'd10,            1'b0, NO_ANSWER},
         {SC_C,                     1'b1, ACT_CHAR,    CHR_ETX, 4'd0, 4'b0100},
         {SC_S,                     1'b1, ACT_CHAR,    CHR_DC3, 4'd0, 4'b0100},
         {SC_Q,                     1'b1, ACT_CHAR,    CHR_DC1, 4'd0, 4'b0100},
         {SC_LALT,                  1'b0, NO_ANSWER},
         {SC_ESC_PREFIX,            1'b0, NO_ANSWER},
         {SC_DEL,                   1'b1, ACT_RESET,   5'd0,    4'd0, 4'b1100},
         {SC_ESC_PREFIX,            1'b0, NO_ANSWER},
         {SC_BREAK,                 1'b1, ACT_CHAR,    CHR_ETX, 4'd0, 4'b1100},
         {SC_ESC_PREFIX,            1'b0, NO_ANSWER},
         {SC_ESC_PREFIX,            1'b0, NO_ANSWER},
         {SC_ESC_PREFIX,            1'b0, NO_ANSWER},
         {SC_LCTRL,                 1'b0, NO_ANSWER},
         {SC_LCTRL | SC_RELEASE,    1'b0, NO_ANSWER},
         {SC_F1,                    1'b0, NO_ANSWER},
         {SC_S,                     1'b0, NO_ANSWER},
         {8'hE1,                    1'b0, NO_ANSWER},
         {SC_LSHIFT,                1'b0, NO_ANSWER},
         {SC_ESC_PREFIX,            1'b0, NO_ANSWER},
         {SC_LCTRL | SC_RELEASE,    1'b0, NO_ANSWER},
         {SC_LALT | SC_RELEASE,     1'b0, NO_ANSWER}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_code(directed_table[i].code, directed_table[i].typed,
                   directed_table[i].answer);
      drain();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 4)
            0: begin
               send_gap_max = 15;
               recv_wait_max = 15;
            end
            1: begin
               send_gap_max = 0;
               recv_wait_max = 0;
            end
            2: begin
               send_gap_max = 0;
               recv_wait_max = 15;
            end
            default: begin
               send_gap_max = 15;
               recv_wait_max = 0;
            end
         endcase
         // Back-to-back offers against a long receiver hold fill the pipe.
         if (seg == 2) hold_request = 1'b1;
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            choice = $urandom_range(0, 9);
            if (choice < 3) begin
               case ($urandom_range(0, 2))
                  0: code = SC_LCTRL;
                  1: code = SC_LALT;
                  default: code = SC_LSHIFT;
               endcase
               if ($urandom_range(0, 4) < 2) code = code | SC_RELEASE;
            end else if (choice < 5) begin
               send_code(SC_ESC_PREFIX, 1'b0, NO_ANSWER);
               case ($urandom_range(0, 5))
                  0: code = SC_LCTRL;
                  1: code = SC_DEL;
                  2: code = SC_BREAK;
                  3: code = SC_LALT;
                  4: code = SC_LSHIFT;
                  default: code = 8'($urandom_range(0, 255));
               endcase
               if ($urandom_range(0, 2) == 0) code = code | SC_RELEASE;
            end else if (choice < 6) begin
               code = SC_F1 - 8'd1 + 8'($urandom_range(0, 11));
            end else if (choice < 8) begin
               case ($urandom_range(0, 2))
                  0: code = SC_C;
                  1: code = SC_S;
                  default: code = SC_Q;
               endcase
            end else begin
               code = 8'($urandom_range(0, 255));
            end
            send_code(code, 1'b0, NO_ANSWER);
         end
         if (seg == 4) drain();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_decisions.size() != 0)
         note_failure($sformatf("%0d decisions never arrived", expected_decisions.size()));
      $display("covered %0d scancodes over %0d segments of mixed idling, incl. a long hold",
               sent_count, SEGMENTS);
      $display("decisions: %0d pass, %0d control char, %0d console switch, %0d reset combo",
               action_tally[ACT_PASS], action_tally[ACT_CHAR], action_tally[ACT_CONSOLE],
               action_tally[ACT_RESET]);
      if (failures == 0) begin
         $display("scancode_hotkey_decoder_top regression: pass");
      end else begin
         $display("scancode_hotkey_decoder_top regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== scancode_hotkey_decoder_top.f =====
rtl/core/shd_pkg.sv
rtl/core/shd_decode.sv
rtl/core/scancode_hotkey_decoder_top.sv
tb/tb_scancode_hotkey_decoder_top.sv
